FILE: rtl/igd_pkg.sv
// ----------------------------------------------------------------------------
// igd_pkg : shared types and constants for the interval group de-dup unit
// Field widths, overlap mode codes, sequencer states and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package igd_pkg;

	localparam int DEPTH_DEF    = 64;
	localparam int POS_BITS_DEF = 32;
	localparam int INDEX_W      = 6;
	localparam int CHROM_W      = 8;
	localparam int CODE_W       = 4;
	localparam int MODE_W       = 2;

	localparam logic [MODE_W-1:0] MODE_EXACT     = 2'd1;
	localparam logic [MODE_W-1:0] MODE_HALF      = 2'd2;
	localparam logic [MODE_W-1:0] MODE_HALF_KIND = 2'd3;
	localparam logic [MODE_W-1:0] MODE_RESET     = MODE_EXACT;

	localparam logic [CODE_W-1:0] KIND_REF = 4'd0;

	typedef enum logic [4:0] {
		ST_LOAD,
		ST_START,
		ST_FIND_RD,
		ST_FIND_EV,
		ST_EMIT_WAIT,
		ST_GINIT,
		ST_SCAN_RD,
		ST_SCAN_EV,
		ST_GEND,
		ST_CAND_RD,
		ST_CAND_EV,
		ST_CNT_RD,
		ST_CNT_EV,
		ST_CAND_END,
		ST_PICK_RD,
		ST_PICK_EV,
		ST_FINISH
	} igd_state_t;

	typedef struct packed {
		logic in_en;      // take input words
		logic ptr_zero;
		logic ptr_inc;
		logic ptr_first;  // ptr <= group head, clear best class
		logic ptr_next;   // ptr <= group head + 1
		logic rd_ptr;
		logic rd_j;
		logic rd_best;
		logic grp_init;
		logic join_rec;
		logic cand_init;
		logic j_inc;
		logic cnt_step;
		logic cand_close;
		logic pend_load;
		logic out_pend;
		logic out_empty;
		logic out_last;
		logic batch_clr;
	} igd_cmd_t;

	typedef struct packed {
		logic batch_end;  // word with tlast accepted
		logic ptr_end;    // ptr at or past record count
		logic ptr_past;   // ptr beyond last group member
		logic j_past;
		logic skip;       // record at ptr used or reference
		logic grp_ptr;
		logic grp_j;
		logic brk;        // scan stops here
		logic joins;
		logic pend_v;
		logic out_free;
	} igd_sts_t;

endpackage

FILE: rtl/igd_ctrl.sv
// ----------------------------------------------------------------------------
// igd_ctrl : sequencer for the interval group de-dup unit
// Steps load, head search, group scan, class tally and result emission.
// ----------------------------------------------------------------------------
module igd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  igd_pkg::igd_sts_t sts,
	output igd_pkg::igd_cmd_t cmd
);
	import igd_pkg::*;

	igd_state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		unique case (state_q)
			ST_LOAD: begin
				cmd.in_en = 1'b1;
				if (sts.batch_end) state_nx = ST_START;
			end
			ST_START: begin
				cmd.ptr_zero = 1'b1;
				state_nx     = ST_FIND_RD;
			end
			ST_FIND_RD: begin
				if (sts.ptr_end) begin
					state_nx = ST_FINISH;
				end else begin
					cmd.rd_ptr = 1'b1;
					state_nx   = ST_FIND_EV;
				end
			end
			ST_FIND_EV: begin
				if (sts.skip) begin
					cmd.ptr_inc = 1'b1;
					state_nx    = ST_FIND_RD;
				end else if (sts.pend_v) begin
					state_nx = ST_EMIT_WAIT;
				end else begin
					state_nx = ST_GINIT;
				end
			end
			ST_EMIT_WAIT: begin
				if (sts.out_free) begin
					cmd.out_pend = 1'b1;
					state_nx     = ST_GINIT;
				end
			end
			ST_GINIT: begin
				cmd.grp_init = 1'b1;
				cmd.ptr_inc  = 1'b1;
				state_nx     = ST_SCAN_RD;
			end
			ST_SCAN_RD: begin
				if (sts.ptr_end) begin
					state_nx = ST_GEND;
				end else begin
					cmd.rd_ptr = 1'b1;
					state_nx   = ST_SCAN_EV;
				end
			end
			ST_SCAN_EV: begin
				if (!sts.skip && sts.brk) begin
					state_nx = ST_GEND;
				end else begin
					cmd.join_rec = !sts.skip && sts.joins;
					cmd.ptr_inc  = 1'b1;
					state_nx     = ST_SCAN_RD;
				end
			end
			ST_GEND: begin
				cmd.ptr_first = 1'b1;
				state_nx      = ST_CAND_RD;
			end
			ST_CAND_RD: begin
				if (sts.ptr_past) begin
					state_nx = ST_PICK_RD;
				end else if (!sts.grp_ptr) begin
					cmd.ptr_inc = 1'b1;
				end else begin
					cmd.rd_ptr = 1'b1;
					state_nx   = ST_CAND_EV;
				end
			end
			ST_CAND_EV: begin
				cmd.cand_init = 1'b1;
				state_nx      = ST_CNT_RD;
			end
			ST_CNT_RD: begin
				if (sts.j_past) begin
					state_nx = ST_CAND_END;
				end else if (!sts.grp_j) begin
					cmd.j_inc = 1'b1;
				end else begin
					cmd.rd_j = 1'b1;
					state_nx = ST_CNT_EV;
				end
			end
			ST_CNT_EV: begin
				cmd.cnt_step = 1'b1;
				cmd.j_inc    = 1'b1;
				state_nx     = ST_CNT_RD;
			end
			ST_CAND_END: begin
				cmd.cand_close = 1'b1;
				cmd.ptr_inc    = 1'b1;
				state_nx       = ST_CAND_RD;
			end
			ST_PICK_RD: begin
				cmd.rd_best = 1'b1;
				state_nx    = ST_PICK_EV;
			end
			ST_PICK_EV: begin
				cmd.pend_load = 1'b1;
				cmd.ptr_next  = 1'b1;
				state_nx      = ST_FIND_RD;
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.out_pend  = sts.pend_v;
					cmd.out_empty = !sts.pend_v;
					cmd.out_last  = 1'b1;
					cmd.batch_clr = 1'b1;
					state_nx      = ST_LOAD;
				end
			end
			default: state_nx = ST_LOAD;
		endcase
	end

endmodule

FILE: rtl/igd_dp.sv
// ----------------------------------------------------------------------------
// igd_dp : datapath of the interval group de-dup unit
// Record memory, used and member flags, overlap test, class tally and the
// output register.
// ----------------------------------------------------------------------------
module igd_dp #(
	parameter int DEPTH    = igd_pkg::DEPTH_DEF,
	parameter int POS_BITS = igd_pkg::POS_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  igd_pkg::igd_cmd_t           cmd,
	output igd_pkg::igd_sts_t           sts,
	input  logic                        cfg_we,
	input  logic [igd_pkg::MODE_W-1:0]  cfg_wdata,
	input  logic                        in_valid,
	input  logic [igd_pkg::CHROM_W-1:0] in_chrom,
	input  logic [POS_BITS-1:0]         in_start,
	input  logic [POS_BITS-1:0]         in_end,
	input  logic [igd_pkg::CODE_W-1:0]  in_kind,
	input  logic [igd_pkg::CODE_W-1:0]  in_zyg,
	input  logic                        in_last,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [igd_pkg::INDEX_W-1:0] out_index,
	output logic [igd_pkg::CHROM_W-1:0] out_chrom,
	output logic [POS_BITS-1:0]         out_start,
	output logic [POS_BITS-1:0]         out_end,
	output logic [igd_pkg::CODE_W-1:0]  out_kind,
	output logic [igd_pkg::CODE_W-1:0]  out_zyg,
	output logic                        out_empty,
	output logic                        out_ovf,
	output logic                        out_last
);
	import igd_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int REC_W = CHROM_W + 2 * POS_BITS + 2 * CODE_W;
	localparam int O_ST  = CHROM_W;
	localparam int O_EN  = CHROM_W + POS_BITS;
	localparam int O_KD  = CHROM_W + 2 * POS_BITS;
	localparam int O_ZY  = O_KD + CODE_W;

	logic [REC_W-1:0] mem_q [DEPTH];
	logic [REC_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q, ptr_q, j_q, first_q, lst_idx_q, cand_q, cbi_q;
	logic [CNT_W-1:0] cnt_q, best_cnt_q, best_sel_q, pend_idx_q;
	logic [DEPTH-1:0] used_q, grp_q;
	logic             ovf_q, pend_v_q, o_v_q, nf_q;
	logic [MODE_W-1:0] mode_q;

	logic [CHROM_W-1:0]  lchrom_q;
	logic [POS_BITS-1:0] lstart_q, lend_q, fend_q;
	logic [CODE_W-1:0]   lkind_q, ckind_q, czyg_q;
	logic signed [POS_BITS:0] ll_q, cbl_q;
	logic [REC_W-1:0] pend_q;

	logic [CHROM_W-1:0]  rd_chrom;
	logic [POS_BITS-1:0] rd_start, rd_end;
	logic [CODE_W-1:0]   rd_kind, rd_zyg;
	logic signed [POS_BITS:0]   len_rd, op, mn;
	logic signed [POS_BITS+1:0] op2;
	logic accept, exact, half, kind_ok, key_hit;
	logic [IDX_W-1:0] rd_addr;
	logic rd_en;

	assign rd_chrom = rd_q[CHROM_W-1:0];
	assign rd_start = rd_q[O_ST +: POS_BITS];
	assign rd_end   = rd_q[O_EN +: POS_BITS];
	assign rd_kind  = rd_q[O_KD +: CODE_W];
	assign rd_zyg   = rd_q[O_ZY +: CODE_W];

	assign accept  = cmd.in_en && in_valid;
	assign len_rd  = $signed({1'b0, rd_end}) - $signed({1'b0, rd_start});
	assign op      = $signed({1'b0, lend_q}) - $signed({1'b0, rd_start});
	assign op2     = {op, 1'b0};
	assign mn      = (ll_q < len_rd) ? ll_q : len_rd;
	assign exact   = (lstart_q == rd_start) && (lend_q == rd_end);
	assign half    = (op2 > $signed({mn[POS_BITS], mn})) && (fend_q >= rd_start);
	assign kind_ok = (mode_q != MODE_HALF_KIND) || (lkind_q == rd_kind);
	assign key_hit = (rd_kind == ckind_q) && (rd_zyg == czyg_q);

	always_comb begin
		rd_en   = cmd.rd_ptr || cmd.rd_j || cmd.rd_best;
		rd_addr = ptr_q[IDX_W-1:0];
		priority if (cmd.rd_j) begin
			rd_addr = j_q[IDX_W-1:0];
		end else if (cmd.rd_best) begin
			rd_addr = best_sel_q[IDX_W-1:0];
		end
	end

	always_comb begin
		sts.batch_end = accept && in_last;
		sts.ptr_end   = ptr_q >= count_q;
		sts.ptr_past  = ptr_q > lst_idx_q;
		sts.j_past    = j_q > lst_idx_q;
		sts.skip      = used_q[ptr_q[IDX_W-1:0]] || (rd_kind == KIND_REF);
		sts.grp_ptr   = grp_q[ptr_q[IDX_W-1:0]];
		sts.grp_j     = grp_q[j_q[IDX_W-1:0]];
		sts.brk       = (lchrom_q != rd_chrom) || (lend_q <= rd_start);
		sts.joins     = (mode_q == MODE_HALF || mode_q == MODE_HALF_KIND) ?
		                (half && kind_ok) : exact;
		sts.pend_v    = pend_v_q;
		sts.out_free  = !o_v_q || out_ready;
	end

	// record memory
	always_ff @(posedge clk) begin
		if (accept && count_q < CNT_W'(DEPTH)) begin
			mem_q[count_q[IDX_W-1:0]] <= {in_zyg, in_kind, in_end, in_start, in_chrom};
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_RESET;
			count_q  <= '0;
			ovf_q    <= 1'b0;
			used_q   <= '0;
			grp_q    <= '0;
			pend_v_q <= 1'b0;
			o_v_q    <= 1'b0;
		end else begin
			if (cfg_we) mode_q <= cfg_wdata;
			if (accept) begin
				if (count_q < CNT_W'(DEPTH)) count_q <= count_q + 1'b1;
				else ovf_q <= 1'b1;
			end
			if (cmd.grp_init) begin
				used_q[ptr_q[IDX_W-1:0]] <= 1'b1;
				grp_q <= DEPTH'(1) << ptr_q[IDX_W-1:0];
			end
			if (cmd.join_rec) begin
				used_q[ptr_q[IDX_W-1:0]] <= 1'b1;
				grp_q[ptr_q[IDX_W-1:0]]  <= 1'b1;
			end
			if (cmd.pend_load) pend_v_q <= 1'b1;
			if (cmd.out_pend) pend_v_q <= 1'b0;
			if (cmd.out_pend || cmd.out_empty) o_v_q <= 1'b1;
			else if (out_ready) o_v_q <= 1'b0;
			if (cmd.batch_clr) begin
				count_q  <= '0;
				ovf_q    <= 1'b0;
				used_q   <= '0;
				pend_v_q <= 1'b0;
			end
		end
	end

	// scan pointers, group and class registers
	always_ff @(posedge clk) begin
		if (cmd.ptr_zero) ptr_q <= '0;
		if (cmd.ptr_inc) ptr_q <= ptr_q + 1'b1;
		if (cmd.ptr_next) ptr_q <= first_q + 1'b1;
		if (cmd.ptr_first) begin
			ptr_q      <= first_q;
			best_cnt_q <= '0;
		end
		if (cmd.grp_init) begin
			first_q <= ptr_q;
			fend_q  <= rd_end;
		end
		if (cmd.grp_init || cmd.join_rec) begin
			lst_idx_q <= ptr_q;
			lchrom_q  <= rd_chrom;
			lstart_q  <= rd_start;
			lend_q    <= rd_end;
			lkind_q   <= rd_kind;
			ll_q      <= len_rd;
		end
		if (cmd.cand_init) begin
			cand_q  <= ptr_q;
			ckind_q <= rd_kind;
			czyg_q  <= rd_zyg;
			cnt_q   <= '0;
			nf_q    <= 1'b0;
			j_q     <= first_q;
		end
		if (cmd.j_inc) j_q <= j_q + 1'b1;
		if (cmd.cnt_step && key_hit) begin
			if (j_q < cand_q) nf_q <= 1'b1;
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == '0 || len_rd < cbl_q) begin
				cbl_q <= len_rd;
				cbi_q <= j_q;
			end
		end
		if (cmd.cand_close && !nf_q && cnt_q > best_cnt_q) begin
			best_cnt_q <= cnt_q;
			best_sel_q <= cbi_q;
		end
		if (cmd.pend_load) begin
			pend_q     <= rd_q;
			pend_idx_q <= best_sel_q;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_pend) begin
			out_index <= INDEX_W'(pend_idx_q);
			out_chrom <= pend_q[CHROM_W-1:0];
			out_start <= pend_q[O_ST +: POS_BITS];
			out_end   <= pend_q[O_EN +: POS_BITS];
			out_kind  <= pend_q[O_KD +: CODE_W];
			out_zyg   <= pend_q[O_ZY +: CODE_W];
			out_empty <= 1'b0;
			out_ovf   <= ovf_q;
			out_last  <= cmd.out_last;
		end else if (cmd.out_empty) begin
			out_index <= '0;
			out_chrom <= '0;
			out_start <= '0;
			out_end   <= '0;
			out_kind  <= '0;
			out_zyg   <= '0;
			out_empty <= 1'b1;
			out_ovf   <= ovf_q;
			out_last  <= 1'b1;
		end
	end

	assign out_valid = o_v_q;

endmodule

FILE: rtl/interval_group_dedup_unit.sv
// ----------------------------------------------------------------------------
// interval_group_dedup_unit : batch de-duplication of sorted interval records
// Stores a batch, groups overlapping records and emits one kept record per
// group.
// ----------------------------------------------------------------------------
// channel  dir  handshake                 payload
// s_axis   in   tvalid/tready             tdata record, tlast ends batch
// m_axis   out  tvalid/tready             tdata kept record, tuser flags,
//                                         tlast on final word of batch
// cfg      in   cfg_we (no back-pressure) cfg_wdata overlap mode
//
// Loading takes one word a cycle; s_axis_tready is low from the batch's
// final word until its last result is loaded into the output register.
// Processing: each record visit in the head search and the group scan takes
// a read state and an evaluate state (one memory read port, registered read
// data). Each group scan runs from its head up to the break, so a batch of n
// records can take in the order of n*n/2 visits when records neither join
// nor stop the scan. The class tally sweeps the group span once per member,
// with a read state and a count state for each member and only a skip for
// any other record.
// Reset clears counts and flags at once; the record memory needs no clear.
// Results wait in an output register while the sequencer holds for tready.
// ----------------------------------------------------------------------------
module interval_group_dedup_unit #(
	parameter int DEPTH    = igd_pkg::DEPTH_DEF,
	parameter int POS_BITS = igd_pkg::POS_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [igd_pkg::MODE_W-1:0] cfg_wdata,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// chrom, start_pos, end_pos, kind_code, zygosity_code, zero fill
	input  logic [((16 + 2 * POS_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
	input  logic                       s_axis_tlast,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// kept_index, kept_chrom, kept_start, kept_end, kept_kind,
	// kept_zygosity, zero fill
	output logic [((22 + 2 * POS_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
	// batch_empty, load_overflow
	output logic [1:0]                 m_axis_tuser,
	output logic                       m_axis_tlast
);
	import igd_pkg::*;

	localparam int OUT_W = ((22 + 2 * POS_BITS + 7) / 8) * 8;
	localparam int I_EN  = CHROM_W + POS_BITS;
	localparam int I_KD  = CHROM_W + 2 * POS_BITS;

	igd_cmd_t cmd;
	igd_sts_t sts;

	logic [INDEX_W-1:0]  o_idx;
	logic [CHROM_W-1:0]  o_chrom;
	logic [POS_BITS-1:0] o_start, o_end;
	logic [CODE_W-1:0]   o_kind, o_zyg;
	logic                o_empty, o_ovf;

	igd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	igd_dp #(
		.DEPTH    (DEPTH),
		.POS_BITS (POS_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_axis_tvalid),
		.in_chrom  (s_axis_tdata[CHROM_W-1:0]),
		.in_start  (s_axis_tdata[CHROM_W +: POS_BITS]),
		.in_end    (s_axis_tdata[I_EN +: POS_BITS]),
		.in_kind   (s_axis_tdata[I_KD +: CODE_W]),
		.in_zyg    (s_axis_tdata[I_KD + CODE_W +: CODE_W]),
		.in_last   (s_axis_tlast),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_index (o_idx),
		.out_chrom (o_chrom),
		.out_start (o_start),
		.out_end   (o_end),
		.out_kind  (o_kind),
		.out_zyg   (o_zyg),
		.out_empty (o_empty),
		.out_ovf   (o_ovf),
		.out_last  (m_axis_tlast)
	);

	// ready only while loading
	assign s_axis_tready = cmd.in_en;
	assign m_axis_tdata  = OUT_W'({o_zyg, o_kind, o_end, o_start, o_chrom, o_idx});
	assign m_axis_tuser  = {o_ovf, o_empty};

endmodule

FILE: rtl/igd_checker.sv
// ----------------------------------------------------------------------------
// igd_checker : port-level checks for the interval group de-dup unit
// Watches the stream ports; bound to the top level below.
// ----------------------------------------------------------------------------
module igd_checker #(
	parameter int IN_W  = 80,
	parameter int OUT_W = 88
) (
	input logic             clk,
	input logic             arst_n,
	input logic             s_axis_tvalid,
	input logic             s_axis_tready,
	input logic [IN_W-1:0]  s_axis_tdata,
	input logic             s_axis_tlast,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [OUT_W-1:0] m_axis_tdata,
	input logic [1:0]       m_axis_tuser,
	input logic             m_axis_tlast
);

	// batch end stops intake for processing
	a_stop_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
		else $error("intake not stopped after batch end");

	// mid-batch results never coexist with loading
	a_no_load_mid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
		else $error("loading while batch results pending");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast && (m_axis_tdata == '0))
		else $error("empty marker malformed");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word changed while stalled");

endmodule

bind interval_group_dedup_unit igd_checker #(
	.IN_W  (((16 + 2 * POS_BITS + 7) / 8) * 8),
	.OUT_W (OUT_W)
) u_igd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
